/* hdl/hptv_pkg.sv */
// Shared types and constants for the host:port token validator.
package hptv_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned PortW   = 16;
  localparam int unsigned HostLenW = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [6:0]          LabelMax  = 7'd63;
  localparam logic [HostLenW-1:0] HostMax   = 8'd253;
  localparam logic [PortW-1:0]    PortReset = 16'd443;
  localparam logic [16:0]         PortMax   = 17'd65535;

  localparam logic [CharW-1:0] ChColon  = 8'h3A;
  localparam logic [CharW-1:0] ChDot    = 8'h2E;
  localparam logic [CharW-1:0] ChHyphen = 8'h2D;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDefaultPort = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxHostLen  = 1'd1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_PORT = 2'd1,
    STATUS_BAD_HOST = 2'd2
  } status_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             has_char;
    logic             last_char;
  } item_t;

  typedef struct packed {
    logic                accepted;
    status_e             status;
    logic [PortW-1:0]    port_number;
    logic [HostLenW-1:0] host_length;
  } result_t;

endpackage

/* hdl/hptv_stream_if.sv */
// Valid/ready channels for token bytes in and verdicts out.
interface hptv_in_if;
  import hptv_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             has_char;
  logic             last_char;

  modport source (output valid, output char_code, output has_char, output last_char,
                  input ready);
  modport sink (input valid, input char_code, input has_char, input last_char,
                output ready);
endinterface

interface hptv_out_if;
  import hptv_pkg::*;
  logic                valid;
  logic                ready;
  logic                accepted;
  logic [1:0]          status;
  logic [PortW-1:0]    port_number;
  logic [HostLenW-1:0] host_length;

  modport source (output valid, output accepted, output status, output port_number,
                  output host_length, input ready);
  modport sink (input valid, input accepted, input status, input port_number,
                input host_length, output ready);
endinterface

/* hdl/hptv_core.sv */
// Per-token state and the verdict logic for one byte item.
module hptv_core
  import hptv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  item_t               item_i,
  input  logic [PortW-1:0]    default_port_i,
  input  logic [HostLenW-1:0] max_host_len_i,
  output result_t             result_o
);

  typedef struct packed {
    logic                in_port;
    logic [7:0]          host_cnt;
    logic [6:0]          label_cnt;
    logic                prev_hyphen;
    logic                host_bad;
    logic [16:0]         port_acc;
    logic                digit_seen;
    logic                port_bad;
  } token_t;

  token_t tok_q, tok_d, upd;

  logic [CharW-1:0]    c;
  logic                is_digit, is_alpha;
  logic [19:0]         port_mul;
  logic [HostLenW-1:0] limit;
  logic                host_fail, port_fail;
  logic [PortW-1:0]    port_val;
  status_e             status;

  assign c        = item_i.char_code;
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  assign port_mul = ({3'b000, tok_q.port_acc} << 3) + ({3'b000, tok_q.port_acc} << 1)
                  + {16'd0, c[3:0]};

  always_comb begin
    upd = tok_q;
    if (fire_i && item_i.has_char) begin
      if (tok_q.in_port) begin
        if (!is_digit) begin
          upd.port_bad = 1'b1;
        end else begin
          upd.digit_seen = 1'b1;
          if (port_mul > {3'b000, PortMax}) begin
            upd.port_bad = 1'b1;
            upd.port_acc = PortMax + 17'd1;
          end else begin
            upd.port_acc = port_mul[16:0];
          end
        end
      end else if (c == ChColon) begin
        upd.in_port = 1'b1;
      end else begin
        if (tok_q.host_cnt != 8'hFF) upd.host_cnt = tok_q.host_cnt + 8'd1;
        if (c == ChDot) begin
          if (tok_q.label_cnt == 7'd0 || tok_q.prev_hyphen) upd.host_bad = 1'b1;
          upd.label_cnt   = 7'd0;
          upd.prev_hyphen = 1'b0;
        end else begin
          if (c == ChHyphen) begin
            if (tok_q.label_cnt == 7'd0) upd.host_bad = 1'b1;
            upd.prev_hyphen = 1'b1;
          end else begin
            if (!(is_digit || is_alpha)) upd.host_bad = 1'b1;
            upd.prev_hyphen = 1'b0;
          end
          // label count saturates one past the limit
          if (tok_q.label_cnt <= LabelMax) upd.label_cnt = tok_q.label_cnt + 7'd1;
          if (upd.label_cnt > LabelMax) upd.host_bad = 1'b1;
        end
      end
    end
  end

  assign limit     = (max_host_len_i > HostMax) ? HostMax : max_host_len_i;
  assign host_fail = upd.host_bad || (upd.host_cnt == 8'd0) || (upd.host_cnt > limit)
                   || (upd.label_cnt == 7'd0) || upd.prev_hyphen;

  always_comb begin
    if (upd.in_port) begin
      port_fail = upd.port_bad || !upd.digit_seen || (upd.port_acc == 17'd0)
                || (upd.port_acc > PortMax);
      port_val  = upd.port_acc[PortW-1:0];
    end else begin
      port_fail = (default_port_i == '0);
      port_val  = default_port_i;
    end
  end

  // Port errors take precedence over hostname errors
  always_comb begin
    priority if (port_fail) status = STATUS_BAD_PORT;
    else if (host_fail)     status = STATUS_BAD_HOST;
    else                    status = STATUS_OK;
  end

  always_comb begin
    result_o.status      = status;
    result_o.accepted    = (status == STATUS_OK);
    result_o.port_number = (status == STATUS_OK) ? port_val : '0;
    result_o.host_length = (upd.host_cnt > HostMax) ? HostMax : upd.host_cnt;
  end

  // Clear the token once its verdict is out
  assign tok_d = (fire_i && item_i.last_char) ? '0 : upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

endmodule

/* hdl/host_port_token_validator.sv */
// Top level: input register, token check, verdict register and config registers.
// A token's last item passes the input register and hptv_core; its verdict is then registered for out_if.
// Throughput: one item per cycle while no verdict is stalled; hptv_core updates the token state as each item fires.
// A verdict held by a low out_if.ready holds the input register and so stalls input.
// Reset (rst_ni, async, active low) empties both stages, clears the token state and
// loads default_port = 443 and max_host_length = 253.
module host_port_token_validator
  import hptv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  hptv_in_if.sink             in_if,
  hptv_out_if.source          out_if
);

  logic                s1_valid_q;
  item_t               s1_item_q;
  logic                out_valid_q;
  result_t             result_q;
  result_t             core_result;
  logic [PortW-1:0]    default_port_q;
  logic [HostLenW-1:0] max_host_len_q;
  logic                out_stall, s1_fire, in_take;

  assign out_stall   = out_valid_q && !out_if.ready;
  assign s1_fire     = s1_valid_q && !out_stall;
  assign in_if.ready = !s1_valid_q || !out_stall;
  assign in_take     = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_port_q <= PortReset;
      max_host_len_q <= HostMax;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgDefaultPort) default_port_q <= cfg_wdata_i[PortW-1:0];
      if (cfg_index_i == CfgMaxHostLen)  max_host_len_q <= cfg_wdata_i[HostLenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.char_code <= in_if.char_code;
      s1_item_q.has_char  <= in_if.has_char;
      s1_item_q.last_char <= in_if.last_char;
    end
  end

  hptv_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (s1_fire),
    .item_i         (s1_item_q),
    .default_port_i (default_port_q),
    .max_host_len_i (max_host_len_q),
    .result_o       (core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_item_q.last_char) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_item_q.last_char) begin
      result_q <= core_result;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.accepted    = result_q.accepted;
  assign out_if.status      = result_q.status;
  assign out_if.port_number = result_q.port_number;
  assign out_if.host_length = result_q.host_length;

`ifndef NO_ASSERTIONS
  a_last_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_item_q.last_char) |=> out_valid_q)
    else $error("last item processed without a verdict");

  a_stall_holds_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> (out_valid_q && $stable(result_q)))
    else $error("verdict changed while stalled");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_stall) |-> !in_if.ready)
    else $error("input taken while both stages are blocked");

  a_reject_zero_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_item_q.last_char && core_result.status != STATUS_OK)
      |=> (result_q.port_number == '0 && !result_q.accepted))
    else $error("rejected token reports a port");
`endif

endmodule
